// File: design/paletted_texture_sampler_top_defines.svh
// Assertion macros for the texel unit. Clock i_clk, reset i_rst_n in scope.
`ifndef PALETTED_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define PALETTED_TEXTURE_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pts_pkg.sv
package pts_pkg;

    localparam int TEXTURE_BYTES_DEF = 65536;
    localparam int PALETTE_WORDS_DEF = 8192;

    // zero-extended address width before wrapping to a store depth
    localparam int ADDR_EXT_W = 24;

    localparam logic [1:0] MODE_TEX_WR = 2'd0;
    localparam logic [1:0] MODE_PAL_WR = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    localparam logic [0:0] REG_TEX_PARAM = 1'd0;
    localparam logic [0:0] REG_PAL_BASE  = 1'd1;

    localparam logic [14:0] COLOR_NONE   = 15'h7FFF;
    localparam logic [14:0] COLOR_4X4    = 15'h0999;
    localparam logic [14:0] COLOR_MASK   = 15'h7FFF;

    typedef enum logic [2:0] {
        FMT_NONE   = 3'd0,
        FMT_A3I5   = 3'd1,
        FMT_2BPP   = 3'd2,
        FMT_4BPP   = 3'd3,
        FMT_8BPP   = 3'd4,
        FMT_4X4    = 3'd5,
        FMT_A5I3   = 3'd6,
        FMT_DIRECT = 3'd7
    } t_fmt;

    typedef struct packed {
        logic        c0t;
        t_fmt        fmt;
        logic [2:0]  size_v;
        logic [2:0]  size_u;
        logic        mir_v;
        logic        mir_u;
        logic        rep_v;
        logic        rep_u;
        logic [15:0] base;
    } t_tparam;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        write_address;
        logic [15:0]        write_data;
        logic signed [15:0] u_coord;
        logic signed [15:0] v_coord;
    } t_item;

    typedef struct packed {
        logic [14:0] texel_color;
        logic        is_transparent;
    } t_result;

    typedef struct packed {
        logic [0:0]  index;
        logic [29:0] value;
    } t_cfg;

    // decode of one texture byte
    typedef struct packed {
        logic        need_pal;
        logic        transp;
        logic [14:0] color;
    } t_dec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_PAL,
        ST_LOAD
    } t_state;

endpackage

// File: design/pts_chan_if.sv
interface pts_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/paletted_texture_sampler_top.sv
// A sample goes through RD0 and RD1, then to LOAD for formats none and 4x4 and for
//   palette texels transparent by their texture byte; a palette read passes PAL and a
//   second direct-color byte read RD2 before LOAD. Result backpressure stalls LOAD.
// Samples do not overlap: a new one is taken only in IDLE, after the dependent reads
//   via the registered-read memories; writes and ignored beats go one per idle cycle.
// Reset: synchronous, active low; clears both config registers and the sequencer.
`include "paletted_texture_sampler_top_defines.svh"

module paletted_texture_sampler_top #(
    parameter int TEXTURE_BYTES = pts_pkg::TEXTURE_BYTES_DEF,
    parameter int PALETTE_WORDS = pts_pkg::PALETTE_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_chan_if.sink   i_item,
    pts_chan_if.sink   i_cfg,
    pts_chan_if.source o_result
);
    import pts_pkg::*;

    localparam int TAW = $clog2(TEXTURE_BYTES);
    localparam int PAW = $clog2(PALETTE_WORDS);

    // ---------------------------------------------------------------------
    // Configuration. Users must write only while idle; the block does not
    // enforce it. Samples use live registers. The stores are not cleared.
    // ---------------------------------------------------------------------
    t_tparam     r_param;
    logic [12:0] r_pal_base;
    t_cfg        cfg;

    assign cfg         = i_cfg.data;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param    <= '0;
            r_pal_base <= '0;
        end else if (i_cfg.valid) begin
            unique case (cfg.index)
                REG_TEX_PARAM: r_param    <= t_tparam'(cfg.value);
                REG_PAL_BASE:  r_pal_base <= cfg.value[12:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input beat decode. Writes go straight into the stores at the accept
    // edge; a sample starts the sequencer. Mode three is dropped.
    // ---------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    t_item  item;
    logic   in_acc;
    logic   sample_acc;
    logic   tex_we;
    logic   pal_we;
    logic [ADDR_EXT_W-1:0] wa_ext;

    assign item       = i_item.data;
    assign in_acc     = i_item.valid && i_item.ready;
    assign sample_acc = in_acc && item.mode == MODE_SAMPLE;
    assign tex_we     = in_acc && item.mode == MODE_TEX_WR;
    assign pal_we     = in_acc && item.mode == MODE_PAL_WR;
    assign wa_ext     = ADDR_EXT_W'(item.write_address);

    // ---------------------------------------------------------------------
    // Coordinate unit: wrap/clamp/mirror and byte address, registered.
    // ---------------------------------------------------------------------
    logic [TAW-1:0] addr0;
    logic [TAW-1:0] addr1;
    logic [1:0]     sub;

    pts_addr #(.TAW(TAW)) u_addr (
        .i_clk   (i_clk),
        .i_load  (sample_acc),
        .i_u     (item.u_coord),
        .i_v     (item.v_coord),
        .i_param (r_param),
        .o_addr0 (addr0),
        .o_addr1 (addr1),
        .o_sub   (sub)
    );

    // ---------------------------------------------------------------------
    // Stores. Input ready is held low while a sample is in flight, which is
    // the interlock: no write can land between a read and its use.
    // ---------------------------------------------------------------------
    logic [TAW-1:0] tex_raddr;
    logic [7:0]     tex_rdata;
    logic [PAW-1:0] pal_raddr;
    logic [15:0]    pal_rdata;

    pts_ram #(.WIDTH(8), .DEPTH(TEXTURE_BYTES)) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr (wa_ext[TAW-1:0]),
        .i_wdata (item.write_data[7:0]),
        .i_raddr (tex_raddr),
        .o_rdata (tex_rdata)
    );

    pts_ram #(.WIDTH(16), .DEPTH(PALETTE_WORDS)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (wa_ext[PAW-1:0]),
        .i_wdata (item.write_data),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    // ---------------------------------------------------------------------
    // Texel decode of the first byte read; also yields the palette address,
    // which feeds the palette read port while in RD1.
    // ---------------------------------------------------------------------
    t_dec dec;

    pts_decode #(.PAW(PAW)) u_decode (
        .i_fmt      (r_param.fmt),
        .i_c0t      (r_param.c0t),
        .i_byte     (tex_rdata),
        .i_sub      (sub),
        .i_pal_base (r_pal_base),
        .o_dec      (dec),
        .o_pal_addr (pal_raddr)
    );

    // ---------------------------------------------------------------------
    // Result holding register: a finished result waits here so that write
    // beats keep flowing; the sequencer parks in LOAD if it is still full.
    // ---------------------------------------------------------------------
    t_result     r_res;
    logic        r_res_valid;
    logic        slot_free;
    logic [7:0]  r_b0;
    logic [14:0] r_pend_color;
    logic        r_pend_transp;
    logic [14:0] n_pend_color;
    logic        n_pend_transp;
    logic [15:0] direct_hw;

    assign slot_free = !r_res_valid || o_result.ready;
    assign direct_hw = {tex_rdata, r_b0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (sample_acc) n_state = ST_RD0;
            ST_RD0:  n_state = ST_RD1;
            ST_RD1: begin
                if (r_param.fmt == FMT_DIRECT) begin
                    n_state = ST_RD2;
                end else if (dec.need_pal) begin
                    n_state = ST_PAL;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_RD2:  n_state = ST_LOAD;
            ST_PAL:  n_state = ST_LOAD;
            ST_LOAD: if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_item.ready  = 1'b0;
        tex_raddr     = addr0;
        n_pend_color  = r_pend_color;
        n_pend_transp = r_pend_transp;
        unique case (r_state)
            ST_IDLE: i_item.ready = 1'b1;
            ST_RD0:  tex_raddr = addr0;
            ST_RD1: begin
                // second byte of a direct-color texel
                tex_raddr     = addr1;
                n_pend_color  = dec.color;
                n_pend_transp = dec.transp;
            end
            ST_RD2: begin
                // alpha bit clear means transparent
                n_pend_transp = !direct_hw[15];
                n_pend_color  = direct_hw[14:0];
            end
            ST_PAL: begin
                n_pend_color  = pal_rdata[14:0] & COLOR_MASK;
                n_pend_transp = 1'b0;
            end
            ST_LOAD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOAD && slot_free) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_color  <= n_pend_color;
        r_pend_transp <= n_pend_transp;
        if (r_state == ST_RD1) begin
            r_b0 <= tex_rdata;
        end
        if (r_state == ST_LOAD && slot_free) begin
            r_res.texel_color    <= r_pend_transp ? 15'd0 : r_pend_color;
            r_res.is_transparent <= r_pend_transp;
        end
    end

    assign o_result.valid = r_res_valid;
    assign o_result.data  = r_res;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PTS_ASSERT_NOW(a_no_write_in_flight, tex_we || pal_we, r_state == ST_IDLE,
        "store write during sample")
    `PTS_ASSERT_NOW(a_pal_only_palette, r_state == ST_PAL,
        r_param.fmt != FMT_NONE && r_param.fmt != FMT_4X4 && r_param.fmt != FMT_DIRECT,
        "palette read for non-palette format")
    `PTS_ASSERT_NEXT(a_load_shows_result, r_state == ST_LOAD && slot_free,
        o_result.valid && r_state == ST_IDLE, "loaded result not presented")

endmodule

// File: design/pts_ram.sv
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/pts_addr.sv
module pts_addr #(
    parameter int TAW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic signed [15:0]     i_u,
    input  logic signed [15:0]     i_v,
    input  pts_pkg::t_tparam       i_param,
    output logic [TAW-1:0]         o_addr0,
    output logic [TAW-1:0]         o_addr1,
    output logic [1:0]             o_sub
);
    import pts_pkg::*;

    // integer texel index, clamped or wrapped (and mirrored) into [0, 8<<s)
    function automatic logic [9:0] texel_index(logic [11:0] c, logic [2:0] s,
                                               logic rep, logic mir);
        logic [3:0]  lg;
        logic [10:0] size;
        logic [9:0]  mask;
        logic        in_rng;
        logic        flip;
        lg     = {1'b0, s} + 4'd3;
        size   = 11'd8 << s;
        mask   = 10'(size - 11'd1);
        in_rng = !c[11] && (c[10:0] < size);
        flip   = mir && c[lg];
        if (in_rng) begin
            return c[9:0];
        end else if (!rep) begin
            return c[11] ? 10'd0 : mask;
        end else begin
            return (c[9:0] & mask) ^ (flip ? mask : 10'd0);
        end
    endfunction

    logic [9:0]  x;
    logic [9:0]  y;
    logic [3:0]  lg_u;
    logic [20:0] off;
    logic [22:0] boff;
    logic [22:0] sum;
    logic [TAW-1:0] r_addr0;
    logic [TAW-1:0] r_addr1;
    logic [1:0]     r_sub;

    // floor(coord / 16) is the top 12 bits of the 12.4 value
    assign x    = texel_index(i_u[15:4], i_param.size_u, i_param.rep_u, i_param.mir_u);
    assign y    = texel_index(i_v[15:4], i_param.size_v, i_param.rep_v, i_param.mir_v);
    assign lg_u = {1'b0, i_param.size_u} + 4'd3;
    assign off  = (21'(y) << lg_u) + 21'(x);

    always_comb begin
        case (i_param.fmt)
            FMT_2BPP:   boff = 23'(off >> 2);
            FMT_4BPP:   boff = 23'(off >> 1);
            FMT_DIRECT: boff = {1'b0, off, 1'b0};
            default:    boff = {2'b0, off};
        endcase
    end

    assign sum = {4'b0, i_param.base, 3'b0} + boff;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr0 <= sum[TAW-1:0];
            r_addr1 <= sum[TAW-1:0] + TAW'(1);
            r_sub   <= off[1:0];
        end
    end

    assign o_addr0 = r_addr0;
    assign o_addr1 = r_addr1;
    assign o_sub   = r_sub;
endmodule

// File: design/pts_decode.sv
module pts_decode #(
    parameter int PAW = 13
) (
    input  pts_pkg::t_fmt  i_fmt,
    input  logic           i_c0t,
    input  logic [7:0]     i_byte,
    input  logic [1:0]     i_sub,
    input  logic [12:0]    i_pal_base,
    output pts_pkg::t_dec  o_dec,
    output logic [PAW-1:0] o_pal_addr
);
    import pts_pkg::*;

    logic [7:0]  idx;
    logic [16:0] pal_full;

    always_comb begin
        idx   = 8'd0;
        o_dec = '{need_pal: 1'b0, transp: 1'b0, color: 15'd0};
        unique case (i_fmt)
            FMT_NONE: begin
                o_dec.color = COLOR_NONE;
            end
            FMT_A3I5: begin
                idx          = {3'b0, i_byte[4:0]};
                o_dec.transp = (i_byte[7:5] == 3'd0) || (i_c0t && idx == 8'd0);
            end
            FMT_2BPP: begin
                idx          = 8'((i_byte >> {i_sub, 1'b0}) & 8'd3);
                o_dec.transp = i_c0t && idx == 8'd0;
            end
            FMT_4BPP: begin
                idx          = {4'b0, i_sub[0] ? i_byte[7:4] : i_byte[3:0]};
                o_dec.transp = i_c0t && idx == 8'd0;
            end
            FMT_8BPP: begin
                idx          = i_byte;
                o_dec.transp = i_c0t && idx == 8'd0;
            end
            FMT_4X4: begin
                o_dec.color = COLOR_4X4;
            end
            FMT_A5I3: begin
                idx          = {5'b0, i_byte[2:0]};
                o_dec.transp = (i_byte[7:3] == 5'd0) || (i_c0t && idx == 8'd0);
            end
            FMT_DIRECT: begin
                // two-byte color, resolved by the sequencer
            end
            default: begin
            end
        endcase
        if (i_fmt == FMT_A3I5 || i_fmt == FMT_2BPP || i_fmt == FMT_4BPP ||
            i_fmt == FMT_8BPP || i_fmt == FMT_A5I3) begin
            o_dec.need_pal = !o_dec.transp;
        end
    end

    // 2bpp palettes sit on 8-byte boundaries, the others on 16-byte ones
    assign pal_full   = ((i_fmt == FMT_2BPP) ? {2'b0, i_pal_base, 2'b0}
                                             : {1'b0, i_pal_base, 3'b0}) + 17'(idx);
    assign o_pal_addr = pal_full[PAW-1:0];
endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    // Mode code 3 is not defined by the block; it must be dropped silently.
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam int TEX_DEPTH       = TEXTURE_BYTES_DEF;
    localparam int PAL_DEPTH       = PALETTE_WORDS_DEF;
    localparam int ITEM_TARGET     = 1750;
    // Settle longer than the worst sample latency so that a trailing write
    // (which yields no result) is surely retired.
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    // Longest legal quiet stretch is the hold-off plus a sender gap and the
    // pipeline; the limit is several times that.
    localparam int WATCHDOG_LIMIT  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pts_chan_if #(.T(t_item))   item_if ();
    pts_chan_if #(.T(t_cfg))    cfg_if ();
    pts_chan_if #(.T(t_result)) res_if ();

    paletted_texture_sampler_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // What one sample reads and what it should return.
    typedef struct {
        logic [15:0] ta0;
        logic [15:0] ta1;
        int          n_tex;
        bit          pal_used;
        logic [12:0] pal_addr;
        t_result     res;
    } t_texel_fetch;

    // Shadow copies of the stores and registers, updated as beats are accepted.
    logic [7:0]  tex_model [TEX_DEPTH];
    logic [15:0] pal_model [PAL_DEPTH];
    bit          tex_seen  [TEX_DEPTH];
    bit          pal_seen  [PAL_DEPTH];
    t_tparam     tparam_model   = '0;
    logic [12:0] pal_base_model = '0;

    t_result pending_texels [$];
    t_result want_texel;

    int mismatches     = 0;
    int texels_checked = 0;
    int items_sent     = 0;
    int reg_writes     = 0;
    int burst_left     = 0;
    int hold_req       = 0;
    int quiet_cycles   = 0;

    // Floor a 12.4 coordinate to a texel, then clamp, wrap or mirror it.
    function automatic int unsigned texel_coord(logic signed [15:0] raw, logic [2:0] size_code,
                                                logic rep, logic mir);
        int          c;
        int          lg;
        int          size;
        int unsigned mask;
        int unsigned uc;
        c    = int'(raw) >>> 4;
        lg   = int'(size_code) + 3;
        size = 1 << lg;
        mask = size - 1;
        if (c >= 0 && c < size) return c;
        if (!rep) return (c < 0) ? 0 : mask;
        uc = unsigned'(c);
        // odd repeat count flips the index when mirroring
        if (mir && ((uc >> lg) & 1) != 0) return (uc & mask) ^ mask;
        return uc & mask;
    endfunction

    // Addresses touched by a sample under the current registers, and its texel.
    // Store addresses wrap by truncation to the store depth.
    function automatic t_texel_fetch texel_lookup(logic signed [15:0] u, logic signed [15:0] v);
        t_texel_fetch f;
        int unsigned  x;
        int unsigned  y;
        int unsigned  off;
        int unsigned  tex_base;
        int unsigned  pal_origin;
        int unsigned  idx;
        logic [7:0]   b;
        logic [15:0]  hw;
        logic [14:0]  color;
        bit           transp;
        bit           alpha_zero;
        f.ta0      = '0;
        f.ta1      = '0;
        f.n_tex    = 0;
        f.pal_used = 1'b0;
        f.pal_addr = '0;
        x   = texel_coord(u, tparam_model.size_u, tparam_model.rep_u, tparam_model.mir_u);
        y   = texel_coord(v, tparam_model.size_v, tparam_model.rep_v, tparam_model.mir_v);
        off = y * (32'd8 << tparam_model.size_u) + x;
        tex_base   = 32'(tparam_model.base) << 3;
        // 2bpp palettes are based in 8-byte units, the others in 16-byte units
        pal_origin = 32'(pal_base_model) << ((tparam_model.fmt == FMT_2BPP) ? 2 : 3);
        color      = '0;
        transp     = 1'b0;
        alpha_zero = 1'b0;
        idx        = 0;
        b          = '0;
        case (tparam_model.fmt)
            FMT_NONE: color = COLOR_NONE;
            FMT_4X4:  color = COLOR_4X4;
            FMT_DIRECT: begin
                f.ta0   = 16'(tex_base + 2 * off);
                f.ta1   = 16'(tex_base + 2 * off + 1);
                f.n_tex = 2;
                hw = {tex_model[f.ta1], tex_model[f.ta0]};
                // clear alpha bit means transparent
                if (!hw[15]) transp = 1'b1;
                else color = hw[14:0];
            end
            default: begin
                f.n_tex    = 1;
                f.pal_used = 1'b1;
                case (tparam_model.fmt)
                    FMT_2BPP: begin
                        f.ta0 = 16'(tex_base + (off >> 2));
                        b     = tex_model[f.ta0];
                        idx   = (b >> (2 * (off & 3))) & 3;
                    end
                    FMT_4BPP: begin
                        f.ta0 = 16'(tex_base + (off >> 1));
                        b     = tex_model[f.ta0];
                        idx   = (b >> (4 * (off & 1))) & 15;
                    end
                    FMT_A3I5: begin
                        f.ta0      = 16'(tex_base + off);
                        b          = tex_model[f.ta0];
                        idx        = 32'(b[4:0]);
                        alpha_zero = (b[7:5] == 3'd0);
                    end
                    FMT_A5I3: begin
                        f.ta0      = 16'(tex_base + off);
                        b          = tex_model[f.ta0];
                        idx        = 32'(b[2:0]);
                        alpha_zero = (b[7:3] == 5'd0);
                    end
                    default: begin
                        f.ta0 = 16'(tex_base + off);
                        b     = tex_model[f.ta0];
                        idx   = 32'(b);
                    end
                endcase
                f.pal_addr = 13'(pal_origin + idx);
                if (alpha_zero || (tparam_model.c0t && idx == 0)) transp = 1'b1;
                else color = pal_model[f.pal_addr][14:0];  // palette bit 15 is dropped
            end
        endcase
        f.res.texel_color    = transp ? 15'd0 : color;
        f.res.is_transparent = transp;
        return f;
    endfunction

    // Apply one accepted item to the shadow state.
    function automatic void track_item(t_item it);
        t_texel_fetch f;
        case (it.mode)
            MODE_TEX_WR: begin
                tex_model[it.write_address] = it.write_data[7:0];
                tex_seen[it.write_address]  = 1'b1;
            end
            MODE_PAL_WR: begin
                pal_model[it.write_address[12:0]] = it.write_data;
                pal_seen[it.write_address[12:0]]  = 1'b1;
            end
            MODE_SAMPLE: begin
                f = texel_lookup(it.u_coord, it.v_coord);
                pending_texels.push_back(f.res);
            end
            default: ;
        endcase
    endfunction

    function automatic t_item random_item(logic [1:0] mode);
        t_item it;
        it.mode          = mode;
        it.write_address = 16'($urandom);
        it.write_data    = 16'($urandom);
        it.u_coord       = 16'($urandom);
        it.v_coord       = 16'($urandom);
        return it;
    endfunction

    // Mostly in range, some just outside (clamp/wrap/mirror), some anywhere.
    function automatic logic signed [15:0] rand_coord(logic [2:0] size_code);
        int size;
        int c;
        int pick;
        size = 8 << size_code;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            c = $urandom_range(0, size - 1);
        end else if (pick < 8) begin
            c = int'($urandom_range(0, 8 * size)) - 4 * size;
            if (c < -2048) c = -2048;
            if (c > 2047) c = 2047;
        end else begin
            return 16'($urandom);
        end
        return 16'(c * 16 + int'($urandom_range(0, 15)));
    endfunction

    // One item beat. The sender runs in bursts with idle gaps in between;
    // within this task, valid is lowered only at a burst boundary.
    task automatic send_item(t_item it);
        bit fire;
        if (burst_left == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        // ready is stable by the falling edge; it decides the next rising edge
        do begin
            @(negedge i_clk);
            fire = item_if.ready;
            @(posedge i_clk);
        end while (!fire);
        track_item(it);
        items_sent++;
    endtask

    // Sender pause: no more items until every texel is back and the pipe is empty.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [29:0] value);
        bit fire;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: index, value: value};
        do begin
            @(negedge i_clk);
            fire = cfg_if.ready;
            @(posedge i_clk);
        end while (!fire);
        if (index == REG_TEX_PARAM) tparam_model = t_tparam'(value);
        else pal_base_model = value[12:0];
        reg_writes++;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the block idle.
    task automatic configure(t_tparam tp, logic [12:0] pal_base);
        wait_idle();
        write_reg(REG_TEX_PARAM, 30'(tp));
        write_reg(REG_PAL_BASE, 30'(pal_base));
    endtask

    task automatic write_texture(logic [15:0] addr, logic [7:0] data);
        t_item it;
        it = random_item(MODE_TEX_WR);
        it.write_address   = addr;
        it.write_data[7:0] = data;   // upper byte stays random, must be ignored
        send_item(it);
    endtask

    task automatic write_palette(logic [12:0] addr, logic [15:0] data);
        t_item it;
        it = random_item(MODE_PAL_WR);
        it.write_address = {3'($urandom), addr};   // high bits alias by wrap
        it.write_data    = data;
        send_item(it);
    endtask

    // A sample never reads an unwritten entry: fill any missing texture bytes
    // first, then the palette entry those bytes select.
    task automatic sample_texel(logic signed [15:0] u, logic signed [15:0] v);
        t_texel_fetch f;
        t_item        it;
        f = texel_lookup(u, v);
        if (f.n_tex > 0 && !tex_seen[f.ta0]) write_texture(f.ta0, 8'($urandom));
        if (f.n_tex > 1 && !tex_seen[f.ta1]) write_texture(f.ta1, 8'($urandom));
        f = texel_lookup(u, v);
        if (f.pal_used && !pal_seen[f.pal_addr]) write_palette(f.pal_addr, 16'($urandom));
        it = random_item(MODE_SAMPLE);
        it.u_coord = u;
        it.v_coord = v;
        send_item(it);
    endtask

    function automatic t_tparam plain_tparam(t_fmt fmt, logic c0t);
        t_tparam tp;
        tp     = '0;
        tp.fmt = fmt;
        tp.c0t = c0t;
        return tp;
    endfunction

    // Reset registers select no format; undefined mode is dropped.
    task automatic test_reset_defaults();
        sample_texel(16'sh0000, 16'sh0000);
        send_item(random_item(MODE_IGNORED));
        sample_texel(16'sh7FFF, 16'sh8000);
    endtask

    // Hand-picked A3I5, 8bpp and direct transparency cases on 8x8, mostly at base 0.
    task automatic test_format_decode();
        t_tparam tp;
        configure(plain_tparam(FMT_A3I5, 1'b1), 13'd0);
        write_palette(13'd0, 16'hFFFF);        // bit 15 must not reach the color
        write_palette(13'd5, 16'h8421);
        write_texture(16'd0, 8'h05);           // alpha zero
        sample_texel(16'sh0000, 16'sh0000);
        write_texture(16'd0, 8'hE0);           // index 0 with color-0 transparency
        sample_texel(16'sh0000, 16'sh0000);
        write_texture(16'd0, 8'h25);           // opaque, palette entry 5
        sample_texel(16'sh0000, 16'sh0000);
        configure(plain_tparam(FMT_8BPP, 1'b0), 13'd0);
        write_texture(16'd0, 8'h00);           // index 0 opaque without bit 29
        sample_texel(16'sh0000, 16'sh0000);
        sample_texel(16'sh7FFF, 16'sh8000);    // clamps to the right edge
        configure(plain_tparam(FMT_8BPP, 1'b1), 13'd0);
        sample_texel(16'sh0000, 16'sh0000);
        configure(plain_tparam(FMT_DIRECT, 1'b0), 13'd0);
        write_texture(16'd0, 8'h34);
        write_texture(16'd1, 8'h12);           // alpha clear
        sample_texel(16'sh0000, 16'sh0000);
        write_texture(16'd1, 8'h92);
        sample_texel(16'sh0000, 16'sh0000);
        configure(plain_tparam(FMT_4X4, 1'b1), 13'd0);
        sample_texel(16'sh0000, 16'sh0000);
        // texture base at the top: row 1 wraps round to byte 0
        tp      = plain_tparam(FMT_8BPP, 1'b0);
        tp.base = 16'hFFFF;
        configure(tp, 13'd0);
        sample_texel(16'sh0000, 16'sh0010);
        sample_texel(16'sh0070, 16'sh0000);
    endtask

    // Register extremes: everything set, everything clear.
    task automatic test_config_extremes();
        t_tparam tp;
        configure(t_tparam'(30'h3FFF_FFFF), 13'h1FFF);
        repeat (8) sample_texel(rand_coord(3'd7), rand_coord(3'd7));
        tp     = t_tparam'(30'h3FFF_FFFF);
        tp.fmt = FMT_8BPP;
        configure(tp, 13'h1FFF);
        repeat (8) sample_texel(rand_coord(3'd7), rand_coord(3'd7));
        configure('0, 13'd0);
        repeat (2) sample_texel(rand_coord(3'd0), rand_coord(3'd0));
    endtask

    // Long result stall while items keep coming: input must back up.
    task automatic test_result_backpressure();
        t_tparam tp;
        tp        = plain_tparam(FMT_4BPP, 1'b1);
        tp.size_u = 3'd2;
        tp.size_v = 3'd1;
        tp.rep_u  = 1'b1;
        tp.mir_v  = 1'b1;
        tp.rep_v  = 1'b1;
        configure(tp, 13'($urandom));
        hold_req = HOLD_OFF_CYCLES;
        burst_left = 200;
        repeat (60) sample_texel(rand_coord(tp.size_u), rand_coord(tp.size_v));
        wait_idle();
    endtask

    // Random register settings, each followed by a run of mostly samples.
    task automatic test_random_phases();
        t_tparam     tp;
        logic [12:0] pb;
        int          pick;
        int          n;
        t_item       it;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                tp = t_tparam'(30'h3FFF_FFFF);
            end else if (pick == 1) begin
                tp     = '0;
                tp.fmt = t_fmt'($urandom_range(0, 7));
            end else begin
                tp = t_tparam'(30'($urandom));
            end
            pick = $urandom_range(0, 5);
            pb   = (pick == 0) ? 13'd0 : (pick == 1) ? 13'h1FFF : 13'($urandom);
            configure(tp, pb);
            n = $urandom_range(20, 70);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    sample_texel(rand_coord(tp.size_u), rand_coord(tp.size_v));
                end else if (pick < 82) begin
                    // overwrite texels near the texture so content keeps changing
                    if (pick < 78)
                        write_texture(16'((32'(tp.base) << 3) + $urandom_range(0, 2047)),
                                      8'($urandom));
                    else
                        send_item(random_item(MODE_TEX_WR));
                end else if (pick < 94) begin
                    if (pick < 90)
                        write_palette(13'((32'(pb) << 3) + $urandom_range(0, 255)),
                                      16'($urandom));
                    else
                        send_item(random_item(MODE_PAL_WR));
                end else begin
                    it = random_item(MODE_IGNORED);
                    send_item(it);
                end
            end
        end
    endtask

    // Result receiver: ready follows a random pattern, each drawn for a random run, plus an
    // occasional long hold-off counted here.
    initial begin
        int pattern;
        int pattern_left;
        int hold_cnt;
        bit rdy;
        pattern      = 0;
        pattern_left = 0;
        hold_cnt     = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else begin
                case (pattern)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    // Every result beat is matched against the oldest expected texel.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_texels.size() == 0) begin
                $error("unexpected result beat: texel_color %h is_transparent %b",
                       res_if.data.texel_color, res_if.data.is_transparent);
                mismatches++;
            end else begin
                want_texel = pending_texels.pop_front();
                texels_checked++;
                if (res_if.data.texel_color !== want_texel.texel_color) begin
                    $error("texel_color: expected %h, got %h",
                           want_texel.texel_color, res_if.data.texel_color);
                    mismatches++;
                end
                if (res_if.data.is_transparent !== want_texel.is_transparent) begin
                    $error("is_transparent: expected %b, got %b",
                           want_texel.is_transparent, res_if.data.is_transparent);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any accepted beat on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles, %0d texels outstanding",
                     quiet_cycles, pending_texels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_format_decode();
        test_config_extremes();
        test_result_backpressure();
        test_random_phases();

        wait_idle();
        if (pending_texels.size() != 0) begin
            $error("%0d expected texels never arrived", pending_texels.size());
            mismatches++;
        end

        $display("Sent %0d item beats and %0d register writes; checked %0d texels",
                 items_sent, reg_writes, texels_checked);
        $display("over all formats, clamp/wrap/mirror addressing and a long result stall.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
